@@ hw/rtl/pmb_pkg.sv @@
// Shared types, constants and the control store of the peak meter ballistics block.
package pmb_pkg;

    localparam int LOG_FRAC_BITS_DEF = 6;

    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 13;
    localparam int FLOOR_W    = 7;
    localparam int HOLD_W     = 8;
    localparam int GAIN_W     = 8;
    localparam int DECAY_W    = 12;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int SHIFT_W    = 4;
    localparam int NUM_W      = 19;
    localparam int DIV_STEPS  = 12;
    localparam int OUT_DATA_W = 32;
    localparam int STEP_W     = 3;

    // 20*log10(2) in Q16.
    localparam logic [NUM_W-1:0] DB_PER_OCT_Q16 = NUM_W'(394566);
    localparam logic [POS_W-1:0] FULL_SCALE     = POS_W'(4096);
    localparam logic [POS_W-1:0] REDRAW_TH      = POS_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_FLOOR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DECAY = CFG_IDX_W'(3);

    localparam logic [FLOOR_W-1:0] FLOOR_RST = FLOOR_W'(60);
    localparam logic [HOLD_W-1:0]  HOLD_RST  = HOLD_W'(30);
    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(72);
    localparam logic [DECAY_W-1:0] DECAY_RST = DECAY_W'(61);

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_IN       = STEP_W'(0);
    localparam t_step STEP_SQUARE   = STEP_W'(1);
    localparam t_step STEP_MAG      = STEP_W'(2);
    localparam t_step STEP_DIV_INIT = STEP_W'(3);
    localparam t_step STEP_DIV      = STEP_W'(4);
    localparam t_step STEP_TARGET   = STEP_W'(5);
    localparam t_step STEP_REL      = STEP_W'(6);
    localparam t_step STEP_UPDATE   = STEP_W'(7);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQUARE,
        OP_MAG,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_TARGET,
        OP_REL,
        OP_UPDATE
    } t_op;

    typedef enum logic [1:0] {
        C_NEXT,
        C_NO_IN,
        C_LOOP,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_FRAC,
        CNT_DIV
    } t_cnt;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_cnt  cnt;
        t_step jmp;
    } t_uword;

    typedef struct packed {
        logic [FLOOR_W-1:0] floor_db;
        logic [HOLD_W-1:0]  hold_frames;
        logic [GAIN_W-1:0]  release_gain;
        logic [DECAY_W-1:0] peak_decay;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] level;
        logic [POS_W-1:0] peak;
        logic             redraw;
    } t_result;

    // Control store. A taken condition goes to jmp, otherwise to the next step;
    // the last step wraps around to the input step.
    function automatic t_uword ucode(input t_step s);
        t_uword u;
        u = '{op: OP_NOP, cond: C_NEXT, cnt: CNT_KEEP, jmp: STEP_IN};
        unique case (s)
            STEP_IN:       u = '{op: OP_LOAD,     cond: C_NO_IN,    cnt: CNT_FRAC,
                                 jmp: STEP_IN};
            STEP_SQUARE:   u = '{op: OP_SQUARE,   cond: C_LOOP,     cnt: CNT_KEEP,
                                 jmp: STEP_SQUARE};
            STEP_MAG:      u = '{op: OP_MAG,      cond: C_NEXT,     cnt: CNT_KEEP,
                                 jmp: STEP_IN};
            STEP_DIV_INIT: u = '{op: OP_DIV_INIT, cond: C_NEXT,     cnt: CNT_DIV,
                                 jmp: STEP_IN};
            STEP_DIV:      u = '{op: OP_DIV_STEP, cond: C_LOOP,     cnt: CNT_KEEP,
                                 jmp: STEP_DIV};
            STEP_TARGET:   u = '{op: OP_TARGET,   cond: C_NEXT,     cnt: CNT_KEEP,
                                 jmp: STEP_IN};
            STEP_REL:      u = '{op: OP_REL,      cond: C_NEXT,     cnt: CNT_KEEP,
                                 jmp: STEP_IN};
            STEP_UPDATE:   u = '{op: OP_UPDATE,   cond: C_OUT_BUSY, cnt: CNT_KEEP,
                                 jmp: STEP_UPDATE};
        endcase
        return u;
    endfunction

endpackage

@@ hw/rtl/peak_meter_ballistics.sv @@
// Top level of the peak meter ballistics block: sequencer, configuration and output stage.
//
// Each transaction on the slave stream carries one frame's linear peak sample
// (unsigned Q1.15). The block answers each one with one transaction on the master
// stream: the smoothed bar level and the held peak marker (Q1.12, 0..4096) in
// tdata, and a redraw flag in tuser that is set when either moved by more than 8.
// Work is run by a small control store: a squaring loop of LOG_FRAC_BITS steps
// builds the log fraction, then a bit-serial divider takes 12 steps to scale it by
// the floor. Samples are worked on one at a time: the next is taken only when the
// sequencer has come back to its first step after finishing the previous one.
// The sequencer waits for a new input at its first step and for a free output
// register at its last; while the receiver stalls, the result stays in the output
// register and the block still takes and works on the next sample.
// Registers are written through the plain write port, by the user only while the block is
// idle; the block does not enforce this. Synchronous reset restores the register defaults
// and clears level, peak and hold count; no transaction is pending after reset.
module peak_meter_ballistics #(
    parameter int LOG_FRAC_BITS = pmb_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pmb_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] peak_sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [12:0] bar_level, [25:13] held_peak, [31:26] zero
    output logic [pmb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tuser,   // [0] redraw
    input  logic                            i_cfg_we,
    input  logic [pmb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pmb_pkg::CFG_W-1:0]       i_cfg_data
);
    import pmb_pkg::*;

    localparam int LOOP_MAX = (LOG_FRAC_BITS > DIV_STEPS) ? LOG_FRAC_BITS : DIV_STEPS;
    localparam int CNT_W    = $clog2(LOOP_MAX);

    t_step            r_step;
    t_step            n_step;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_cfg             r_cfg;
    logic             r_out_valid;
    t_result          r_out;

    t_uword  w_uw;
    t_op     w_op;
    logic    w_out_busy;
    logic    w_wait;
    logic    w_loop;
    t_result w_result;

    assign w_uw       = ucode(r_step);
    assign w_out_busy = r_out_valid && !m_axis_tready;
    assign w_wait     = ((w_uw.cond == C_NO_IN) && !s_axis_tvalid) ||
                        ((w_uw.cond == C_OUT_BUSY) && w_out_busy);
    assign w_loop     = (w_uw.cond == C_LOOP) && (r_cnt != '0);
    assign w_op       = w_wait ? OP_NOP : w_uw.op;

    always_comb begin
        n_step = (w_wait || w_loop) ? w_uw.jmp : r_step + STEP_W'(1);
        n_cnt  = r_cnt;
        if (!w_wait) begin
            unique case (w_uw.cnt)
                CNT_FRAC: n_cnt = CNT_W'(LOG_FRAC_BITS - 1);
                CNT_DIV:  n_cnt = CNT_W'(DIV_STEPS - 1);
                CNT_KEEP: n_cnt = w_loop ? r_cnt - CNT_W'(1) : r_cnt;
                default:  n_cnt = r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IN;
            r_cnt  <= '0;
        end else begin
            r_step <= n_step;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{floor_db: FLOOR_RST, hold_frames: HOLD_RST,
                       release_gain: GAIN_RST, peak_decay: DECAY_RST};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FLOOR: r_cfg.floor_db     <= i_cfg_data[FLOOR_W-1:0];
                REG_HOLD:  r_cfg.hold_frames  <= i_cfg_data[HOLD_W-1:0];
                REG_GAIN:  r_cfg.release_gain <= i_cfg_data[GAIN_W-1:0];
                REG_DECAY: r_cfg.peak_decay   <= i_cfg_data[DECAY_W-1:0];
            endcase
        end
    end

    pmb_datapath #(
        .LOG_FRAC_BITS(LOG_FRAC_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op),
        .i_cfg    (r_cfg),
        .i_sample (s_axis_tdata),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_op == OP_UPDATE) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_op == OP_UPDATE) begin
            r_out <= w_result;
        end
    end

    assign s_axis_tready = (w_uw.cond == C_NO_IN);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out.peak, r_out.level});
    assign m_axis_tuser  = r_out.redraw;

    // An accepted sample always starts the squaring loop.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_step == STEP_SQUARE))
        else $error("sequencer did not start after an accepted sample");

    // The last step never leaves without filling the output register.
    a_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == STEP_UPDATE) && !w_out_busy) |=> (r_out_valid && (r_step == STEP_IN)))
        else $error("update step finished without producing a result");

    // Both meter positions stay within full scale.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.level <= FULL_SCALE) && (r_out.peak <= FULL_SCALE)))
        else $error("meter position beyond full scale");

    // The peak marker never sits below the bar.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.peak >= r_out.level))
        else $error("held peak below bar level");

endmodule

@@ hw/rtl/pmb_datapath.sv @@
// Arithmetic datapath of the peak meter: log conversion, divider and ballistics state.
module pmb_datapath #(
    parameter int LOG_FRAC_BITS = pmb_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pmb_pkg::t_op                  i_op,
    input  pmb_pkg::t_cfg                 i_cfg,
    input  logic [pmb_pkg::SAMPLE_W-1:0]  i_sample,
    output pmb_pkg::t_result              o_result
);
    import pmb_pkg::*;

    localparam int MAG_W  = SHIFT_W + LOG_FRAC_BITS;
    localparam int PROD_W = NUM_W + MAG_W;
    localparam int REL_W  = POS_W + GAIN_W;

    logic [SAMPLE_W-1:0]      r_m;
    logic [LOG_FRAC_BITS-1:0] r_frac;
    logic [SHIFT_W-1:0]       r_shift;
    logic                     r_zero;
    logic                     r_full;
    logic [NUM_W-1:0]         r_num;
    logic [FLOOR_W-1:0]       r_rem;
    logic [DIV_STEPS-1:0]     r_quo;
    logic                     r_ovf;
    logic [POS_W-1:0]         r_target;
    logic [REL_W-1:0]         r_rel;
    logic [POS_W-1:0]         r_level;
    logic [POS_W-1:0]         r_peak;
    logic [HOLD_W-1:0]        r_hold;

    logic [SHIFT_W-1:0]       w_shift;
    logic [SAMPLE_W-1:0]      w_norm;
    logic [2*SAMPLE_W-1:0]    w_sq;
    logic [SAMPLE_W:0]        w_sq_hi;
    logic                     w_bit;
    logic [SAMPLE_W-1:0]      w_m_next;
    logic [MAG_W-1:0]         w_mag;
    logic [PROD_W-1:0]        w_prod;
    logic [FLOOR_W-1:0]       w_fl;
    logic [FLOOR_W:0]         w_trial;
    logic                     w_ge;
    logic [POS_W-1:0]         w_gap;
    logic [REL_W-1:0]         w_round;
    logic [POS_W-1:0]         w_fall;
    logic [POS_W-1:0]         w_level_new;
    logic                     w_peak_hit;
    logic [HOLD_W-1:0]        w_hold_dec;
    logic [POS_W-1:0]         w_decay;
    logic [POS_W-1:0]         w_np;
    logic [POS_W-1:0]         w_peak_new;
    logic [HOLD_W-1:0]        w_hold_new;
    logic [POS_W-1:0]         w_dl;
    logic [POS_W-1:0]         w_dp;

    // Shift that brings the leading one of a sample below full scale to the top bit.
    always_comb begin
        w_shift = '0;
        for (int i = 0; i < SAMPLE_W - 1; i++) begin
            if (i_sample[i]) begin
                w_shift = SHIFT_W'(SAMPLE_W - 1 - i);
            end
        end
    end

    assign w_norm = i_sample << w_shift;

    // One fraction bit of log2 per squaring of the Q1.15 mantissa.
    assign w_sq     = r_m * r_m;
    assign w_sq_hi  = w_sq[2*SAMPLE_W-1:SAMPLE_W-1];
    assign w_bit    = w_sq_hi[SAMPLE_W];
    assign w_m_next = w_bit ? w_sq_hi[SAMPLE_W:1] : w_sq_hi[SAMPLE_W-1:0];

    assign w_mag  = {r_shift, {LOG_FRAC_BITS{1'b0}}} - MAG_W'(r_frac);
    assign w_prod = PROD_W'(DB_PER_OCT_Q16) * PROD_W'(w_mag);

    // Restoring divider by the floor, one quotient bit per step.
    assign w_fl    = (i_cfg.floor_db == '0) ? FLOOR_W'(1) : i_cfg.floor_db;
    assign w_trial = {r_rem, r_quo[DIV_STEPS-1]};
    assign w_ge    = w_trial >= {1'b0, w_fl};

    assign w_gap = r_level - r_target;

    // Release rounds the fall up so the level settles on the target.
    assign w_round     = r_rel + REL_W'((1 << GAIN_W) - 1);
    assign w_fall      = w_round[REL_W-1:GAIN_W];
    assign w_level_new = (r_target > r_level) ? r_target : r_level - w_fall;

    assign w_peak_hit = r_target >= r_peak;
    assign w_hold_dec = (r_hold == '0) ? '0 : r_hold - HOLD_W'(1);
    assign w_decay    = POS_W'(i_cfg.peak_decay);
    assign w_np       = (r_peak > w_decay) ? r_peak - w_decay : '0;

    always_comb begin
        if (w_peak_hit) begin
            w_peak_new = r_target;
            w_hold_new = i_cfg.hold_frames;
        end else begin
            w_hold_new = w_hold_dec;
            if (w_hold_dec == '0) begin
                w_peak_new = (w_np > w_level_new) ? w_np : w_level_new;
            end else begin
                w_peak_new = r_peak;
            end
        end
    end

    assign w_dl = (w_level_new > r_level) ? w_level_new - r_level : r_level - w_level_new;
    assign w_dp = (w_peak_new > r_peak) ? w_peak_new - r_peak : r_peak - w_peak_new;

    assign o_result = '{level: w_level_new, peak: w_peak_new,
                        redraw: (w_dl > REDRAW_TH) || (w_dp > REDRAW_TH)};

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_m     <= w_norm;
                r_shift <= w_shift;
                r_frac  <= '0;
                r_zero  <= (i_sample == '0);
                r_full  <= i_sample[SAMPLE_W-1];
            end
            OP_SQUARE: begin
                r_m    <= w_m_next;
                r_frac <= {r_frac[LOG_FRAC_BITS-2:0], w_bit};
            end
            OP_MAG: begin
                r_num <= w_prod[LOG_FRAC_BITS+SHIFT_W +: NUM_W];
            end
            OP_DIV_INIT: begin
                r_rem <= r_num[NUM_W-1 -: FLOOR_W];
                r_quo <= r_num[DIV_STEPS-1:0];
                r_ovf <= r_num[NUM_W-1 -: FLOOR_W] >= w_fl;
            end
            OP_DIV_STEP: begin
                r_rem <= w_ge ? FLOOR_W'(w_trial - {1'b0, w_fl}) : FLOOR_W'(w_trial);
                r_quo <= {r_quo[DIV_STEPS-2:0], w_ge};
            end
            OP_TARGET: begin
                if (r_zero) begin
                    r_target <= '0;
                end else if (r_full) begin
                    r_target <= FULL_SCALE;
                end else if (r_ovf) begin
                    r_target <= '0;
                end else begin
                    r_target <= FULL_SCALE - POS_W'(r_quo);
                end
            end
            OP_REL: begin
                r_rel <= REL_W'(w_gap) * REL_W'(i_cfg.release_gain);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_peak  <= '0;
            r_hold  <= '0;
        end else if (i_op == OP_UPDATE) begin
            r_level <= w_level_new;
            r_peak  <= w_peak_new;
            r_hold  <= w_hold_new;
        end
    end

endmodule

@@ verif/meter_checker.sv @@
// Checker for the peak meter: predicts every reading from the accepted samples and compares.
`timescale 1ns / 100ps

module meter_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [pmb_pkg::SAMPLE_W-1:0]    i_in_sample,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [pmb_pkg::OUT_DATA_W-1:0]  i_out_data,
    input  logic                            i_out_redraw,
    input  logic                            i_cfg_we,
    input  logic [pmb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pmb_pkg::CFG_W-1:0]       i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);
    import pmb_pkg::*;

    localparam int              LFB        = LOG_FRAC_BITS_DEF;
    localparam longint unsigned DB_Q16     = 64'd394566;
    localparam int unsigned     TOP        = 4096;
    localparam int unsigned     MOVE_LIMIT = 8;
    localparam int              REPORT_MAX = 10;

    logic [FLOOR_W-1:0] floor_db;
    logic [HOLD_W-1:0]  hold_frames;
    logic [GAIN_W-1:0]  release_gain;
    logic [DECAY_W-1:0] peak_decay;

    int unsigned bar_now;
    int unsigned peak_now;
    int unsigned hold_left;

    t_result due_readings[$];
    int      mismatches  = 0;
    int      readings_in = 0;

    // Meter position in Q1.12 from the linear sample: leading one plus a
    // fraction built by repeated squaring, then scaled by the floor.
    function automatic int unsigned position_of(input logic [SAMPLE_W-1:0] x);
        int unsigned     lead;
        int unsigned     frac;
        longint unsigned mant;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned den;
        longint unsigned drop;
        int unsigned     fl;
        lead = 0;
        frac = 0;
        if (x == '0) return 0;
        if (x >= 16'h8000) return TOP;
        for (int i = 0; i < SAMPLE_W; i++)
            if (x[i]) lead = i;
        mant = longint'(x) << (15 - lead);
        for (int i = 0; i < LFB; i++) begin
            mant = (mant * mant) >> 15;
            frac = frac << 1;
            if (mant >= 64'd65536) begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        mag  = (longint'(15 - lead) << LFB) - longint'(frac);
        fl   = (floor_db == '0) ? 1 : int'(floor_db);
        num  = DB_Q16 * mag * TOP;
        den  = longint'(fl) << (LFB + 16);
        drop = num / den;
        if (drop >= TOP) return 0;
        return TOP - int'(drop);
    endfunction

    function automatic int unsigned spread(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_result advance_meter(input logic [SAMPLE_W-1:0] x);
        int unsigned target;
        int unsigned was_bar;
        int unsigned was_peak;
        int unsigned fall;
        int unsigned lowered;
        t_result     r;
        target   = position_of(x);
        was_bar  = bar_now;
        was_peak = peak_now;

        // Instant attack; the release rounds up so the bar does reach the target.
        if (target > bar_now) begin
            bar_now = target;
        end else begin
            fall    = ((bar_now - target) * release_gain + 255) >> 8;
            bar_now = bar_now - fall;
        end

        if (target >= peak_now) begin
            peak_now  = target;
            hold_left = hold_frames;
        end else begin
            if (hold_left > 0) hold_left--;
            if (hold_left == 0) begin
                lowered  = (peak_now > peak_decay) ? peak_now - peak_decay : 0;
                peak_now = (lowered > bar_now) ? lowered : bar_now;
            end
        end

        r.level  = POS_W'(bar_now);
        r.peak   = POS_W'(peak_now);
        r.redraw = (spread(bar_now, was_bar) > MOVE_LIMIT) ||
                   (spread(peak_now, was_peak) > MOVE_LIMIT);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            floor_db     = FLOOR_RST;
            hold_frames  = HOLD_RST;
            release_gain = GAIN_RST;
            peak_decay   = DECAY_RST;
            bar_now      = 0;
            peak_now     = 0;
            hold_left    = 0;
            due_readings.delete();
        end else begin
            // Compare before queuing: a sample taken at this edge cannot be answered yet.
            if (i_out_valid && i_out_ready) begin
                got.level  = i_out_data[POS_W-1:0];
                got.peak   = i_out_data[2*POS_W-1:POS_W];
                got.redraw = i_out_redraw;
                readings_in++;
                if (due_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("meter_checker: reading %0d arrived with none due:",
                                 readings_in, " level=%0d peak=%0d redraw=%0b",
                                 got.level, got.peak, got.redraw);
                end else begin
                    want = due_readings.pop_front();
                    if (got.level !== want.level || got.peak !== want.peak ||
                        got.redraw !== want.redraw) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("meter_checker: reading %0d", readings_in,
                                     " expected level=%0d peak=%0d redraw=%0b,",
                                     want.level, want.peak, want.redraw,
                                     " got level=%0d peak=%0d redraw=%0b",
                                     got.level, got.peak, got.redraw);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                due_readings.push_back(advance_meter(i_in_sample));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FLOOR: floor_db     = i_cfg_data[FLOOR_W-1:0];
                    REG_HOLD:  hold_frames  = i_cfg_data[HOLD_W-1:0];
                    REG_GAIN:  release_gain = i_cfg_data[GAIN_W-1:0];
                    REG_DECAY: peak_decay   = i_cfg_data[DECAY_W-1:0];
                    default: ;
                endcase
            end
        end
        o_errors  = mismatches;
        o_pending = due_readings.size();
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the peak meter: stimulus, traffic shaping, configuration phases and verdict.
`timescale 1ns / 100ps

module tb;
    import pmb_pkg::*;

    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE      = 40;
    localparam int STALL_LONG  = 400;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_W-1:0]      i_cfg_data    = '0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    int errors;
    int pending;
    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int hold_off_cycles = 0;
    bit drain_stuck     = 1'b0;

    logic [SAMPLE_W-1:0] probe_samples [20];

    always #5 i_clk = ~i_clk;

    peak_meter_ballistics uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    meter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_sample  (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_redraw (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    // Receiver side. A requested hold-off is counted down here, one cycle per clock.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_off_cycles--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_setting(input int unsigned fl, input int unsigned hold,
                                input int unsigned gain, input int unsigned decay);
        write_reg(REG_FLOOR, fl);
        write_reg(REG_HOLD, hold);
        write_reg(REG_GAIN, gain);
        write_reg(REG_DECAY, decay);
    endtask

    // Traffic knobs change at a rising edge so the receiver process never races them.
    task automatic set_traffic(input int src_pct, input int sink_pct, input int hold_off);
        @(posedge i_clk);
        src_idle_pct    = src_pct;
        sink_stall_pct  = sink_pct;
        hold_off_cycles = hold_off;
        @(negedge i_clk);
    endtask

    task automatic drain_readings();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending != 0) drain_stuck = 1'b1;
    endtask

    // Mostly transients: a hit at a random loudness followed by a quiet tail, long
    // enough now and then to outlast the longest hold. The rest is plain noise.
    task automatic play_program(input int count);
        int                  sent;
        int                  tail_left;
        logic [SAMPLE_W-1:0] x;
        sent      = 0;
        tail_left = 0;
        while (sent < count) begin
            if (tail_left > 0) begin
                if ($urandom_range(3) == 0)
                    x = '0;
                else
                    x = SAMPLE_W'($urandom) >> $urandom_range(4, 15);
                tail_left--;
            end else if ($urandom_range(99) < 75) begin
                x = SAMPLE_W'($urandom) >> $urandom_range(0, 8);
                if ($urandom_range(9) == 0)
                    tail_left = $urandom_range(200, 300);
                else
                    tail_left = $urandom_range(0, 40);
            end else begin
                x = SAMPLE_W'($urandom);
            end
            send_sample(x);
            sent++;
        end
    endtask

    initial begin
        int budget;
        probe_samples = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h8000,
                          16'h7FFF, 16'h4000, 16'h5555, 16'hAAAA, 16'h0100,
                          16'h0002, 16'h0003, 16'h1000, 16'h0000, 16'h0000,
                          16'h0800, 16'hFFFF, 16'h0040, 16'h2000, 16'h0000};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults after reset: full scale, silence, tiny and mid values.
        foreach (probe_samples[k]) send_sample(probe_samples[k]);
        drain_readings();

        for (int phase = 1; phase <= 7; phase++) begin
            budget = 100;
            case (phase)
                1: load_setting(1, 1, 255, 4095);
                2: begin
                    load_setting(120, 255, 1, 1);
                    budget = 250;
                end
                // Zero in every register: floor taken as 1 dB, level never falls,
                // peak falls at once but by nothing.
                3: load_setting(0, 0, 0, 0);
                4: begin
                    load_setting(127, 255, 255, 4095);
                    budget = 250;
                end
                default: load_setting($urandom_range(1, 120), $urandom_range(0, 40),
                                      $urandom_range(1, 255), $urandom_range(1, 300));
            endcase
            case (phase % 4)
                1: set_traffic(68, 0, 0);
                2: set_traffic(0, 68, 0);
                3: set_traffic(23, 23, 0);
                default: set_traffic(0, 0, STALL_LONG);
            endcase
            play_program(budget);
            drain_readings();
        end

        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0 && !drain_stuck)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
